>>> rtl/core/dtsd_pkg.sv
// Shared constants, types and lookup tables for the DShot telemetry sample decoder.
`default_nettype none
package dtsd_pkg;

	localparam int SAMPLE_BITS_DEF = 64;
	localparam int MAX_RUN_DEF     = 16;
	localparam int FRAME_BITS      = 21;
	localparam int ACC_BITS        = 32;
	localparam int MAX_LINE_BITS   = ACC_BITS + FRAME_BITS - 1;
	localparam int WORD_W          = 64;
	localparam int KIND_W          = 4;
	localparam int VALUE_W         = 16;
	localparam int NBITS_W         = 3;
	localparam int RUN_W           = 5;
	localparam int GRP             = 8;
	localparam int CNT_W           = 8;
	localparam int FRAME_W         = 12;
	localparam int NIB_W           = 4;
	localparam int QUINT_W         = 5;
	localparam int NUM_QUINT       = 4;
	localparam int GCR_W           = QUINT_W * NUM_QUINT;
	localparam int WORD16_W        = NIB_W * NUM_QUINT;
	localparam int MANT_W          = 9;
	localparam int EXP_W           = 3;
	localparam int EXT_W           = 8;

	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [FRAME_W-1:0] frame_t;

	localparam kind_t KIND_INVALID = 4'd0;
	localparam kind_t KIND_ERPM    = 4'd1;
	localparam logic [NIB_W-1:0] CSUM_GOOD = 4'hF;

	// run length in samples -> line bits
	function automatic logic [NBITS_W-1:0] run_bits(input logic [RUN_W-1:0] len);
		logic [NBITS_W-1:0] n;
		unique case (len) inside
			5'd0:           n = 3'd0;
			[5'd1:5'd3]:    n = 3'd1;
			[5'd4:5'd6]:    n = 3'd2;
			[5'd7:5'd10]:   n = 3'd3;
			[5'd11:5'd13]:  n = 3'd4;
			default:        n = 3'd5;
		endcase
		return n;
	endfunction

	// GCR 5b -> 4b, unused codes give 0
	function automatic logic [NIB_W-1:0] gcr_nibble(input logic [QUINT_W-1:0] q);
		logic [NIB_W-1:0] n;
		unique case (q)
			5'd9:    n = 4'd9;
			5'd10:   n = 4'd10;
			5'd11:   n = 4'd11;
			5'd13:   n = 4'd13;
			5'd14:   n = 4'd14;
			5'd15:   n = 4'd15;
			5'd18:   n = 4'd2;
			5'd19:   n = 4'd3;
			5'd21:   n = 4'd5;
			5'd22:   n = 4'd6;
			5'd23:   n = 4'd7;
			5'd26:   n = 4'd8;
			5'd27:   n = 4'd1;
			5'd29:   n = 4'd4;
			5'd30:   n = 4'd12;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/dtsd_in_if.sv
// Input channel: one word of line samples with valid/ready handshake.
`default_nettype none
interface dtsd_in_if;
	logic                          valid;
	logic                          ready;
	logic [dtsd_pkg::WORD_W-1:0]   sample_word;

	modport source(output valid, output sample_word, input ready);
	modport sink(input valid, input sample_word, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dtsd_out_if.sv
// Output channel: decoded telemetry kind and value with valid/ready handshake.
`default_nettype none
interface dtsd_out_if;
	logic                  valid;
	logic                  ready;
	dtsd_pkg::kind_t       telemetry_kind;
	dtsd_pkg::value_t      telemetry_value;

	modport source(output valid, output telemetry_kind, output telemetry_value, input ready);
	modport sink(input valid, input telemetry_kind, input telemetry_value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dtsd_run_scan.sv
// Run detection: per-sample run ends, line bits per run, leading-high and long-run checks.
`default_nettype none
module dtsd_run_scan #(
	parameter int SAMPLE_BITS = dtsd_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_RUN     = dtsd_pkg::MAX_RUN_DEF
) (
	input  logic [dtsd_pkg::WORD_W-1:0]                       sample_word,
	output logic [SAMPLE_BITS-1:0][dtsd_pkg::NBITS_W-1:0]     nbits,
	output logic [SAMPLE_BITS-1:0]                            run_end,
	output logic                                              bad
);

	logic [SAMPLE_BITS-1:0]          smp;
	logic [dtsd_pkg::RUN_W-1:0]      len;
	logic                            long_run;

	always_comb begin
		for (int j = 0; j < SAMPLE_BITS; j++) begin
			smp[j] = sample_word[SAMPLE_BITS-1-j];
		end
		run_end[SAMPLE_BITS-1] = 1'b1;
		for (int j = 0; j < SAMPLE_BITS - 1; j++) begin
			run_end[j] = smp[j] ^ smp[j+1];
		end

		// length of the run ending at j: distance back to the previous end
		len = '0;
		for (int j = 0; j < SAMPLE_BITS; j++) begin
			len = '0;
			for (int d = MAX_RUN; d >= 1; d--) begin
				if (j - d == -1) begin
					len = dtsd_pkg::RUN_W'(d);
				end else if (j - d >= 0) begin
					if (run_end[j-d]) begin
						len = dtsd_pkg::RUN_W'(d);
					end
				end
			end
			nbits[j] = run_end[j] ? dtsd_pkg::run_bits(len) : '0;
		end

		long_run = 1'b0;
		for (int j = 0; j + MAX_RUN <= SAMPLE_BITS - 1; j++) begin
			if (run_end[j +: MAX_RUN] == '0) begin
				long_run = 1'b1;
			end
		end

		bad = sample_word[SAMPLE_BITS-1] | long_run;
	end

endmodule
`default_nettype wire

>>> rtl/core/dtsd_gcr_decode.sv
// Frame alignment, transition-to-NRZ, GCR 5b/4b decode and checksum check.
`default_nettype none
module dtsd_gcr_decode #(
	parameter int POS_W = 7
) (
	input  logic [dtsd_pkg::FRAME_BITS-1:1] bnd,
	input  logic [POS_W-1:0]                count,
	input  logic                            bad,
	output dtsd_pkg::frame_t                frame,
	output logic                            ok
);

	localparam int M_W = $clog2(dtsd_pkg::FRAME_BITS);

	logic [dtsd_pkg::CNT_W-1:0]       cnt;
	logic [M_W-1:0]                   m;
	logic [dtsd_pkg::FRAME_BITS-1:1]  mask;
	logic                             line_m;
	logic [dtsd_pkg::GCR_W-1:0]       gcr_in;
	logic [dtsd_pkg::WORD16_W-1:0]    word16;
	logic [dtsd_pkg::NIB_W-1:0]       csum;
	logic                             range_ok;

	always_comb begin
		cnt = dtsd_pkg::CNT_W'(count);
		range_ok = (cnt >= dtsd_pkg::CNT_W'(dtsd_pkg::FRAME_BITS)) &&
			(cnt <= dtsd_pkg::CNT_W'(dtsd_pkg::MAX_LINE_BITS));
		// leading frame bits lost to accumulator wrap
		m = (cnt > dtsd_pkg::CNT_W'(dtsd_pkg::ACC_BITS)) ?
			M_W'(cnt - dtsd_pkg::CNT_W'(dtsd_pkg::ACC_BITS)) : '0;

		for (int k = 1; k < dtsd_pkg::FRAME_BITS; k++) begin
			mask[k] = (M_W'(k) <= m);
		end
		line_m = ^(bnd & mask);

		for (int k = 1; k < dtsd_pkg::FRAME_BITS; k++) begin
			if (M_W'(k) > m) begin
				gcr_in[dtsd_pkg::FRAME_BITS-1-k] = bnd[k];
			end else if (M_W'(k) == m) begin
				gcr_in[dtsd_pkg::FRAME_BITS-1-k] = line_m;
			end else begin
				gcr_in[dtsd_pkg::FRAME_BITS-1-k] = 1'b0;
			end
		end

		for (int q = 0; q < dtsd_pkg::NUM_QUINT; q++) begin
			word16[q*dtsd_pkg::NIB_W +: dtsd_pkg::NIB_W] =
				dtsd_pkg::gcr_nibble(gcr_in[q*dtsd_pkg::QUINT_W +: dtsd_pkg::QUINT_W]);
		end

		csum = word16[15:12] ^ word16[11:8] ^ word16[7:4] ^ word16[3:0];
		frame = word16[15:4];
		ok = !bad && range_ok && (csum == dtsd_pkg::CSUM_GOOD);
	end

endmodule
`default_nettype wire

>>> rtl/core/dshot_telemetry_sample_decoder_top.sv
// DShot telemetry sample decoder top: sample word in, telemetry kind and value out.
// A result passes the sample register, four stages and the output register before it is valid.
// Throughput: one word per cycle while results are taken; a stage holds its word only while
// the next is full and stalled: a waiting result blocks no new word while bubbles remain.
// Reset: arst_n clears all stage valid flags and the output valid; payload is not reset.
`default_nettype none
module dshot_telemetry_sample_decoder_top #(
	parameter int SAMPLE_BITS = dtsd_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_RUN     = dtsd_pkg::MAX_RUN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	dtsd_in_if.sink         sample_in,
	dtsd_out_if.source      result_out
);

	localparam int POS_W = $clog2(SAMPLE_BITS + 1);
	localparam int NG    = (SAMPLE_BITS + dtsd_pkg::GRP - 1) / dtsd_pkg::GRP;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_out;

	// stage 1: sample register
	logic [dtsd_pkg::WORD_W-1:0] sample_s1;

	// stage 2: line bits per run end
	logic [SAMPLE_BITS-1:0][dtsd_pkg::NBITS_W-1:0] nbits_d, nbits_s2;
	logic [SAMPLE_BITS-1:0]                        end_d, end_s2;
	logic                                          bad_d, bad_s2;

	// stage 3: group-local running sums
	logic [NG-1:0][dtsd_pkg::GRP-1:0][POS_W-1:0] lsum_d, lsum_s3;
	logic [NG-1:0][dtsd_pkg::GRP-1:0]            end_pad_d, end_s3;
	logic [POS_W-1:0]                            acc;
	logic                                        bad_s3;

	// stage 4: run boundaries in the first frame bits, line bit count
	logic [NG-1:0][POS_W-1:0]              off;
	logic [POS_W-1:0]                      run_off;
	logic [POS_W-1:0]                      pos;
	logic [POS_W-1:0]                      count_d, count_s4;
	logic [dtsd_pkg::FRAME_BITS-1:1]       bnd_d, bnd_s4;
	logic                                  bad_s4;

	// stage 5: checked frame
	dtsd_pkg::frame_t frame_d, frame_s5;
	logic             ok_d, ok_s5;

	// output
	logic [dtsd_pkg::NIB_W-1:0]   typ;
	logic [dtsd_pkg::MANT_W-1:0]  mant;
	logic [dtsd_pkg::EXP_W-1:0]   expo;
	dtsd_pkg::kind_t              kind_d, kind_q;
	dtsd_pkg::value_t             value_d, value_q;

	assign ld_out = !out_valid_q || result_out.ready;
	assign ld_s5  = !v_s5 || ld_out;
	assign ld_s4  = !v_s4 || ld_s5;
	assign ld_s3  = !v_s3 || ld_s4;
	assign ld_s2  = !v_s2 || ld_s3;
	assign ld_s1  = !v_s1 || ld_s2;

	assign sample_in.ready            = ld_s1;
	assign result_out.valid           = out_valid_q;
	assign result_out.telemetry_kind  = kind_q;
	assign result_out.telemetry_value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= sample_in.valid;
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
			if (ld_s3) begin
				v_s3 <= v_s2;
			end
			if (ld_s4) begin
				v_s4 <= v_s3;
			end
			if (ld_s5) begin
				v_s5 <= v_s4;
			end
			if (ld_out) begin
				out_valid_q <= v_s5;
			end
		end
	end

	dtsd_run_scan #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_RUN     (MAX_RUN)
	) u_run_scan (
		.sample_word (sample_s1),
		.nbits       (nbits_d),
		.run_end     (end_d),
		.bad         (bad_d)
	);

	always_comb begin
		acc = '0;
		for (int g = 0; g < NG; g++) begin
			acc = '0;
			for (int i = 0; i < dtsd_pkg::GRP; i++) begin
				if (g * dtsd_pkg::GRP + i < SAMPLE_BITS) begin
					acc = acc + POS_W'(nbits_s2[g*dtsd_pkg::GRP+i]);
					end_pad_d[g][i] = end_s2[g*dtsd_pkg::GRP+i];
				end else begin
					end_pad_d[g][i] = 1'b0;
				end
				lsum_d[g][i] = acc;
			end
		end
	end

	always_comb begin
		run_off = '0;
		for (int g = 0; g < NG; g++) begin
			off[g] = run_off;
			run_off = run_off + lsum_s3[g][dtsd_pkg::GRP-1];
		end
		count_d = run_off;

		bnd_d = '0;
		pos = '0;
		for (int g = 0; g < NG; g++) begin
			for (int i = 0; i < dtsd_pkg::GRP; i++) begin
				pos = off[g] + lsum_s3[g][i];
				for (int p = 1; p < dtsd_pkg::FRAME_BITS; p++) begin
					if (end_s3[g][i] && (pos == POS_W'(p))) begin
						bnd_d[p] = 1'b1;
					end
				end
			end
		end
	end

	dtsd_gcr_decode #(
		.POS_W (POS_W)
	) u_gcr_decode (
		.bnd   (bnd_s4),
		.count (count_s4),
		.bad   (bad_s4),
		.frame (frame_d),
		.ok    (ok_d)
	);

	always_comb begin
		typ  = frame_s5[11:8];
		mant = frame_s5[8:0];
		expo = frame_s5[11:9];
		kind_d  = dtsd_pkg::KIND_INVALID;
		value_d = '0;
		if (ok_s5) begin
			if (typ[0] || (typ == '0)) begin
				if (mant != '0) begin
					kind_d  = dtsd_pkg::KIND_ERPM;
					value_d = dtsd_pkg::VALUE_W'(mant) << expo;
				end
			end else begin
				kind_d  = dtsd_pkg::KIND_W'(typ >> 1) + dtsd_pkg::KIND_ERPM;
				value_d = dtsd_pkg::VALUE_W'(frame_s5[dtsd_pkg::EXT_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			sample_s1 <= sample_in.sample_word;
		end
		if (ld_s2) begin
			nbits_s2 <= nbits_d;
			end_s2   <= end_d;
			bad_s2   <= bad_d;
		end
		if (ld_s3) begin
			lsum_s3 <= lsum_d;
			end_s3  <= end_pad_d;
			bad_s3  <= bad_s2;
		end
		if (ld_s4) begin
			bnd_s4   <= bnd_d;
			count_s4 <= count_d;
			bad_s4   <= bad_s3;
		end
		if (ld_s5) begin
			frame_s5 <= frame_d;
			ok_s5    <= ok_d;
		end
		if (ld_out) begin
			kind_q  <= kind_d;
			value_q <= value_d;
		end
	end

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the DShot telemetry sample decoder: frame stimulus, scoreboard.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dtsd_pkg::*;

	typedef struct packed {
		kind_t  kind;
		value_t value;
	} telemetry_t;

	class telemetry_board;
		telemetry_t expected_telemetry[$];
		int mismatches = 0;

		function int line_bits(input int run);
			if (run == 0)
				return 0;
			else if (run <= 3)
				return 1;
			else if (run <= 6)
				return 2;
			else if (run <= 10)
				return 3;
			else if (run <= 13)
				return 4;
			return 5;
		endfunction

		function logic [3:0] quintet_value(input logic [4:0] q);
			case (q)
				5'd9:  return 4'd9;
				5'd10: return 4'd10;
				5'd11: return 4'd11;
				5'd13: return 4'd13;
				5'd14: return 4'd14;
				5'd15: return 4'd15;
				5'd18: return 4'd2;
				5'd19: return 4'd3;
				5'd21: return 4'd5;
				5'd22: return 4'd6;
				5'd23: return 4'd7;
				5'd26: return 4'd8;
				5'd27: return 4'd1;
				5'd29: return 4'd4;
				5'd30: return 4'd12;
				default: return 4'd0;
			endcase
		endfunction

		function void push_run(inout logic [31:0] acc, inout int count, input int run,
				input logic lvl);
			int n;
			n = line_bits(run);
			acc = acc << n;
			if (lvl)
				acc = acc | ((32'd1 << n) - 32'd1);
			count += n;
		endfunction

		function void decode_samples(input logic [63:0] w, output kind_t kind,
				output value_t val);
			logic [31:0] acc, f21, g20;
			logic [15:0] nib16, period;
			logic [11:0] frame;
			logic [3:0] ty, csum;
			logic lvl;
			int count, run, i;
			kind = KIND_INVALID;
			val = '0;
			if (w[63])
				return;
			acc = '0;
			count = 0;
			run = 1;
			lvl = 1'b0;
			for (i = 62; i >= 0; i--) begin
				if (w[i] != lvl) begin
					push_run(acc, count, run, lvl);
					lvl = w[i];
					run = 1;
				end else begin
					run++;
					if (run > MAX_RUN_DEF)
						return;
				end
			end
			push_run(acc, count, run, lvl);
			if (count < FRAME_BITS || count > MAX_LINE_BITS)
				return;
			f21 = acc >> (count - FRAME_BITS);
			g20 = f21 ^ (f21 >> 1);
			nib16 = {quintet_value(g20[19:15]), quintet_value(g20[14:10]),
				quintet_value(g20[9:5]), quintet_value(g20[4:0])};
			csum = nib16[15:12] ^ nib16[11:8] ^ nib16[7:4] ^ nib16[3:0];
			if (csum != CSUM_GOOD)
				return;
			frame = nib16[15:4];
			ty = frame[11:8];
			if (ty[0] || ty == 4'd0) begin
				period = {7'd0, frame[8:0]} << frame[11:9];
				if (period == 16'd0)
					return;
				kind = KIND_ERPM;
				val = period;
			end else begin
				kind = kind_t'({1'b0, ty[3:1]} + 4'd1);
				val = {8'd0, frame[7:0]};
			end
		endfunction

		function void note_word(input logic [63:0] w);
			telemetry_t t;
			kind_t k;
			value_t v;
			decode_samples(w, k, v);
			t.kind = k;
			t.value = v;
			expected_telemetry.push_back(t);
		endfunction

		function void check_result(input kind_t k, input value_t v);
			telemetry_t t;
			if (expected_telemetry.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: kind %0d value %h", k, v);
				mismatches++;
				return;
			end
			t = expected_telemetry.pop_front();
			if (k !== t.kind || v !== t.value) begin
				if (mismatches < 10)
					$display("mismatch: got kind %0d value %h, want kind %0d value %h",
						k, v, t.kind, t.value);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_telemetry.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dtsd_in_if  sample_in();
	dtsd_out_if result_out();

	dshot_telemetry_sample_decoder_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.result_out (result_out)
	);

	telemetry_board board = new();

	bit in_burst = 1'b0;
	bit out_burst = 1'b0;
	int hold_cycles = 0;

	logic [4:0] nibble_code [16] = '{5'h19, 5'h1B, 5'h12, 5'h13, 5'h1D, 5'h15, 5'h16, 5'h17,
		5'h1A, 5'h09, 5'h0A, 5'h0B, 5'h1E, 5'h0D, 5'h0E, 5'h0F};
	logic [4:0] spare_code [5] = '{5'd12, 5'd20, 5'd28, 5'd31, 5'd17};
	int run_lo [6] = '{0, 1, 4, 7, 11, 14};
	int run_hi [6] = '{0, 3, 6, 10, 13, 16};

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && sample_in.valid && sample_in.ready)
			board.note_word(sample_in.sample_word);
		if (arst_n && result_out.valid && result_out.ready)
			board.check_result(result_out.telemetry_kind, result_out.telemetry_value);
	end

	// runs of samples, alternating levels, first run low
	function automatic logic [63:0] word_from_runs(input int runs[$]);
		logic [63:0] w;
		logic lvl;
		int pos;
		w = '0;
		lvl = 1'b0;
		pos = 63;
		foreach (runs[j]) begin
			repeat (runs[j]) begin
				if (pos >= 0)
					w[pos] = lvl;
				pos--;
			end
			lvl = ~lvl;
		end
		while (pos >= 0) begin
			w[pos] = ~lvl;
			pos--;
		end
		return w;
	endfunction

	function automatic logic [63:0] frame_word(input logic [11:0] payload, input bit bad_csum,
			input bit odd_quint);
		logic [3:0] nib [4];
		logic [19:0] g;
		logic [20:0] f;
		int br[$];
		int rl[$];
		int k, b, i, slot, total, remain, len, attempt;
		nib[3] = payload[11:8];
		nib[2] = payload[7:4];
		nib[1] = payload[3:0];
		slot = $urandom_range(1, 3);
		if (odd_quint)
			nib[slot] = 4'd0;
		nib[0] = ~(nib[3] ^ nib[2] ^ nib[1]);
		if (bad_csum)
			nib[0] = nib[0] ^ 4'($urandom_range(1, 15));
		for (i = 0; i < 4; i++)
			g[5*i +: 5] = nibble_code[nib[i]];
		if (odd_quint)
			g[5*slot +: 5] = spare_code[$urandom_range(0, 4)];
		f[20] = 1'b0;
		for (i = 19; i >= 0; i--)
			f[i] = f[i+1] ^ g[i];
		k = 1;
		for (i = 19; i >= 0; i--) begin
			if (f[i] == f[i+1]) begin
				k++;
			end else begin
				br.push_back(k);
				k = 1;
			end
		end
		br.push_back(k);
		total = 0;
		for (attempt = 0; attempt < 2; attempt++) begin
			rl = {};
			total = 0;
			foreach (br[j]) begin
				b = (br[j] > 5) ? 5 : br[j];
				len = (attempt == 0) ? $urandom_range(run_lo[b], run_hi[b]) : run_lo[b];
				rl.push_back(len);
				total += len;
			end
			if (total <= 64)
				break;
		end
		remain = 64 - total;
		while (remain > 0) begin
			len = (remain <= 16) ? remain : $urandom_range(8, 16);
			rl.push_back(len);
			remain -= len;
		end
		return word_from_runs(rl);
	endfunction

	task automatic drive_word(input logic [63:0] w);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			sample_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_in.valid <= 1'b1;
		sample_in.sample_word <= w;
		do @(posedge clk); while (!sample_in.ready);
		@(negedge clk);
	endtask

	initial begin
		int n, gap;
		result_out.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				result_out.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			gap = out_burst ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				result_out.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_out.ready <= 1'b1;
			do @(posedge clk); while (!result_out.valid);
			@(negedge clk);
		end
	end

	initial begin
		int rl[$];
		int r, tot, len;
		logic [63:0] w;
		sample_in.valid = 1'b0;
		sample_in.sample_word = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		drive_word(64'h8000_0000_0000_0000);
		drive_word('1);
		drive_word('0);
		drive_word(64'h0000_FFFF_0000_FFFF);
		drive_word(64'h5555_5555_5555_5555);
		rl = {};
		repeat (40) rl.push_back(1);
		repeat (6) rl.push_back(4);
		drive_word(word_from_runs(rl));
		rl = {};
		repeat (43) rl.push_back(1);
		repeat (4) rl.push_back(4);
		rl.push_back(5);
		drive_word(word_from_runs(rl));
		rl = {17, 3, 3, 3, 16, 16, 6};
		drive_word(word_from_runs(rl));
		drive_word(frame_word(12'h000, 1'b0, 1'b0));
		drive_word(frame_word(12'h001, 1'b0, 1'b0));
		drive_word(frame_word(12'h100, 1'b0, 1'b0));
		drive_word(frame_word(12'h1FF, 1'b0, 1'b0));
		drive_word(frame_word(12'hFFF, 1'b0, 1'b0));
		for (int t = 2; t <= 14; t += 2)
			drive_word(frame_word({4'(t), 8'($urandom_range(0, 255))}, 1'b0, 1'b0));
		drive_word(frame_word(12'h2FF, 1'b0, 1'b0));
		drive_word(frame_word(12'hE00, 1'b0, 1'b0));
		drive_word(frame_word(12'h3A5, 1'b1, 1'b0));
		drive_word(frame_word(12'h4C3, 1'b0, 1'b1));

		for (int i = 0; i < 1400; i++) begin
			if (i % 200 == 0) begin
				in_burst = ($urandom_range(0, 3) == 0);
				out_burst = ($urandom_range(0, 3) == 0);
			end
			if (i == 500 || i == 1100) begin
				in_burst = 1'b1;
				hold_cycles = 80;
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				w = frame_word(12'($urandom_range(0, 4095)), $urandom_range(0, 9) == 0,
					$urandom_range(0, 19) == 0);
			end else if (r < 85) begin
				rl = {};
				tot = 0;
				while (tot < 64) begin
					len = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 20 : 8);
					if (len > 64 - tot)
						len = 64 - tot;
					rl.push_back(len);
					tot += len;
				end
				w = word_from_runs(rl);
			end else begin
				w = {$urandom, $urandom};
				if ($urandom_range(0, 1))
					w[63] = 1'b0;
			end
			drive_word(w);
		end
		sample_in.valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
